/* src/wcts_pkg.sv */
// Package for the wall column texture stepper: field widths, tdata bit
// offsets, fixed-point constants, sequencer states and the divider status type.
// Depends on nothing; every other file in src imports it.
package wcts_pkg;

  // Screen, texture and fixed-point settings. The texture sizes are powers of two.
  localparam int SCREEN_HEIGHT  = 480;
  localparam int TEXTURE_WIDTH  = 64;
  localparam int TEXTURE_HEIGHT = 64;
  localparam int FRACTION_BITS  = 16;

  // Field widths of the items.
  localparam int COL_W   = 10;
  localparam int DIST_W  = 24;
  localparam int POS_W   = 24;
  localparam int RAY_W   = 18;
  localparam int FACE_W  = 2;
  localparam int ROW_W   = 9;
  localparam int TEXX_W  = $clog2(TEXTURE_WIDTH);
  localparam int TEXY_W  = $clog2(TEXTURE_HEIGHT);
  localparam int HGT_W   = 16;
  localparam int STEP_W  = 24;
  localparam int TPOS_W  = 32;
  localparam int FRAC2_W = 2 * FRACTION_BITS;

  // Shared divider: dividend and quotient width, divisor width.
  localparam int DIV_W    = 25;
  localparam int DVSR_W   = 24;
  localparam int DCNT_W   = $clog2(DIV_W);

  // Shared multiplier operand and product widths (signed).
  localparam int MUL_A_W  = 25;
  localparam int MUL_B_W  = 19;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam logic [DIV_W-1:0] H_DIVIDEND    = DIV_W'(SCREEN_HEIGHT * (1 << FRACTION_BITS));
  localparam logic [DIV_W-1:0] STEP_DIVIDEND = DIV_W'(TEXTURE_HEIGHT * (1 << FRACTION_BITS));
  localparam logic [HGT_W-1:0] HEIGHT_MAX    = {HGT_W{1'b1}};
  localparam logic [HGT_W-2:0] HALF_SCREEN   = (HGT_W-1)'(SCREEN_HEIGHT / 2);
  localparam logic [HGT_W-1:0] LAST_ROW      = HGT_W'(SCREEN_HEIGHT - 1);

  // Input tdata layout, lowest bits first.
  localparam int IN_COL_LSB  = 0;
  localparam int IN_DIST_LSB = IN_COL_LSB + COL_W;
  localparam int IN_SIDE_LSB = IN_DIST_LSB + DIST_W;
  localparam int IN_PX_LSB   = IN_SIDE_LSB + 1;
  localparam int IN_PY_LSB   = IN_PX_LSB + POS_W;
  localparam int IN_RX_LSB   = IN_PY_LSB + POS_W;
  localparam int IN_RY_LSB   = IN_RX_LSB + RAY_W;
  localparam int IN_FACE_LSB = IN_RY_LSB + RAY_W;
  localparam int IN_USED_W   = IN_FACE_LSB + FACE_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bits first.
  localparam int OUT_SX_LSB   = 0;
  localparam int OUT_SY_LSB   = OUT_SX_LSB + COL_W;
  localparam int OUT_TX_LSB   = OUT_SY_LSB + ROW_W;
  localparam int OUT_TY_LSB   = OUT_TX_LSB + TEXX_W;
  localparam int OUT_FACE_LSB = OUT_TY_LSB + TEXY_W;
  localparam int OUT_USED_W   = OUT_FACE_LSB + FACE_W;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic {
    OP_SETUP = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DIV_H    = 7'b0000010,
    S_WALL     = 7'b0000100,
    S_TEX      = 7'b0001000,
    S_DIV_STEP = 7'b0010000,
    S_POS      = 7'b0100000,
    S_FIN      = 7'b1000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/wcts_div.sv */
// Shared restoring divider for the wall column texture stepper: one quotient
// bit per cycle, unsigned. Depends on wcts_pkg.
module wcts_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wcts_pkg::DIV_W-1:0]  dividend,
  input  logic [wcts_pkg::DVSR_W-1:0] divisor,
  output logic [wcts_pkg::DIV_W-1:0]  quotient,
  output wcts_pkg::div_stat_t         stat
);
  import wcts_pkg::*;

  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVSR_W-1:0] dvsr_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DVSR_W:0]   shifted;
  logic [DVSR_W+1:0] diff;

  // A zero divisor never underflows, so the quotient comes out all ones.
  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvsr_r};
    if (!diff[DVSR_W+1]) begin
      rem_nxt = diff[DVSR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DVSR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* src/wcts_mul.sv */
// Shared signed multiplier for the wall column texture stepper, with its
// product registered. Depends on wcts_pkg.
module wcts_mul (
  input  logic                                clk,
  input  logic signed [wcts_pkg::MUL_A_W-1:0] mul_a,
  input  logic signed [wcts_pkg::MUL_B_W-1:0] mul_b,
  output logic signed [wcts_pkg::MUL_P_W-1:0] mul_p
);
  import wcts_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign mul_p = prod_r;

endmodule

/* src/wall_column_texture_stepper.sv */
// Top level of the wall column texture stepper: sequencer, span state and
// output register. Depends on wcts_pkg, wcts_div and wcts_mul.
//
// A column setup item (tuser 0) keeps in_tready low until done: the shared
// divider runs the wall height division, then the texture step division if
// the height is not zero, and the shared multiplier is used twice (wall hit
// position, then texture start). A pixel step item (tuser 1) gives one pixel
// item when a span is active, so a whole column streams at one pixel a cycle
// once set up while the receiver keeps up. The result sits in an output
// register, and a new item is taken only when that register is empty or its
// pixel leaves in the same cycle, so a stalled receiver holds the input back.
module wall_column_texture_stepper (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0 up: column, wall_distance, hit_side, player_x,
  // player_y, ray_x, ray_y, wall_face, then zero padding.
  input  logic [wcts_pkg::IN_DATA_W-1:0]  in_tdata,
  // Fields: operation.
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0 up: screen_x, screen_y, texel_x, texel_y,
  // texture_face, then zero padding.
  output logic [wcts_pkg::OUT_DATA_W-1:0] out_tdata,
  // Marks the last pixel of the column span.
  output logic                            out_tlast
);
  import wcts_pkg::*;

  state_t state_r, state_nxt;

  // Input field views.
  logic [COL_W-1:0]         in_col;
  logic [DIST_W-1:0]        in_dist;
  logic                     in_side;
  logic [POS_W-1:0]         in_px, in_py;
  logic signed [RAY_W-1:0]  in_rx, in_ry;
  logic [FACE_W-1:0]        in_face;
  logic                     in_fire, step_fire, setup_fire;

  // Span and pixel state.
  logic                     span_active_r;
  logic [ROW_W-1:0]         current_row_r, span_end_r;
  logic [COL_W-1:0]         held_column_r;
  logic [TEXX_W-1:0]        held_texel_x_r;
  logic [FACE_W-1:0]        held_face_r;
  logic [STEP_W-1:0]        texture_step_r;
  logic [TPOS_W-1:0]        texture_position_r;
  logic                     last_w;

  // Setup working registers.
  logic [DIST_W-1:0]        dist_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [RAY_W-1:0]  ray_r;
  logic                     mirror_r;
  logic [HGT_W-1:0]         height_r;
  logic [HGT_W-2:0]         offset_r;
  logic                     pend_active_r;

  // Span arithmetic from the height.
  logic [HGT_W-2:0]         half_h;
  logic [HGT_W-1:0]         end_sum;
  logic [ROW_W-1:0]         span_start, span_stop;
  logic [HGT_W-2:0]         span_ofs;

  // Texture column from the wall hit.
  logic [FRAC2_W-1:0]       wall_frac;
  logic [TEXX_W-1:0]        tex_col;

  // Output register.
  logic                     out_valid_r;
  logic [COL_W-1:0]         out_sx_r;
  logic [ROW_W-1:0]         out_sy_r;
  logic [TEXX_W-1:0]        out_tx_r;
  logic [TEXY_W-1:0]        out_ty_r;
  logic [FACE_W-1:0]        out_face_r;
  logic                     out_last_r;

  // Shared units.
  logic                       div_start;
  logic [DIV_W-1:0]           div_dividend, div_quo;
  logic [DVSR_W-1:0]          div_divisor;
  div_stat_t                  div_stat;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;

  assign in_col  = in_tdata[IN_COL_LSB  +: COL_W];
  assign in_dist = in_tdata[IN_DIST_LSB +: DIST_W];
  assign in_side = in_tdata[IN_SIDE_LSB];
  assign in_px   = in_tdata[IN_PX_LSB   +: POS_W];
  assign in_py   = in_tdata[IN_PY_LSB   +: POS_W];
  assign in_rx   = in_tdata[IN_RX_LSB   +: RAY_W];
  assign in_ry   = in_tdata[IN_RY_LSB   +: RAY_W];
  assign in_face = in_tdata[IN_FACE_LSB +: FACE_W];

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign step_fire  = in_fire && (in_tuser == OP_STEP);
  assign setup_fire = in_fire && (in_tuser == OP_SETUP);

  assign last_w = ({1'b0, current_row_r} + 1'b1) >= {1'b0, span_end_r};

  // The divider is started once for the height on setup and once for the
  // step, unless the height is zero, in which case the step is simply zero.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = H_DIVIDEND;
    div_divisor  = in_dist;
    if (state_r == S_TEX) begin
      div_dividend = STEP_DIVIDEND;
      div_divisor  = DVSR_W'(height_r);
      div_start    = (height_r != '0);
    end else begin
      div_start    = setup_fire;
    end
  end

  // Multiplier operands: distance times ray for the wall hit, then the
  // texture start offset times the step.
  always_comb begin
    if (state_r == S_POS) begin
      mul_a = MUL_A_W'({1'b0, texture_step_r});
      mul_b = MUL_B_W'({1'b0, offset_r});
    end else begin
      mul_a = MUL_A_W'({1'b0, dist_r});
      mul_b = MUL_B_W'(ray_r);
    end
  end

  // The span is centred on the middle row and clamped to the screen; the
  // offset is how far the clamped top lies inside the wall.
  always_comb begin
    half_h  = height_r[HGT_W-1:1];
    end_sum = {1'b0, half_h} + {1'b0, HALF_SCREEN};
    if (half_h > HALF_SCREEN) begin
      span_start = '0;
      span_ofs   = half_h - HALF_SCREEN;
    end else begin
      span_start = ROW_W'(HALF_SCREEN - half_h);
      span_ofs   = '0;
    end
    if (end_sum >= LAST_ROW) begin
      span_stop = LAST_ROW[ROW_W-1:0];
    end else begin
      span_stop = end_sum[ROW_W-1:0];
    end
  end

  // Fraction of the wall hit with twice the fraction bits; the texture
  // column is its top bits, mirrored by complement when the face is seen
  // from behind.
  always_comb begin
    wall_frac = mul_p[FRAC2_W-1:0] + {pos_r[FRACTION_BITS-1:0], {FRACTION_BITS{1'b0}}};
    tex_col   = wall_frac[FRAC2_W-1 -: TEXX_W];
    if (mirror_r) begin
      tex_col = ~tex_col;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (setup_fire) begin
          state_nxt = S_DIV_H;
        end
      end
      S_DIV_H: begin
        if (div_stat.done) begin
          state_nxt = S_WALL;
        end
      end
      S_WALL: begin
        state_nxt = S_TEX;
      end
      S_TEX: begin
        state_nxt = (height_r != '0) ? S_DIV_STEP : S_POS;
      end
      S_DIV_STEP: begin
        if (div_stat.done) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      span_active_r <= 1'b0;
      current_row_r <= '0;
      span_end_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (setup_fire) begin
        // A new setup drops whatever remains of the old span.
        span_active_r <= 1'b0;
      end
      if (step_fire && span_active_r) begin
        out_valid_r   <= 1'b1;
        current_row_r <= current_row_r + 1'b1;
        if (last_w) begin
          span_active_r <= 1'b0;
        end
      end
      if (state_r == S_WALL) begin
        current_row_r <= span_start;
        span_end_r    <= span_stop;
      end
      if (state_r == S_FIN) begin
        span_active_r <= pend_active_r;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_column_r      <= '0;
      held_texel_x_r     <= '0;
      held_face_r        <= '0;
      texture_step_r     <= '0;
      texture_position_r <= '0;
    end else begin
      if (setup_fire) begin
        held_column_r <= in_col;
        held_face_r   <= in_face;
      end
      if (step_fire && span_active_r) begin
        texture_position_r <= texture_position_r + TPOS_W'(texture_step_r);
      end
      if (state_r == S_TEX) begin
        held_texel_x_r <= tex_col;
        if (height_r == '0) begin
          texture_step_r <= '0;
        end
      end
      if ((state_r == S_DIV_STEP) && div_stat.done) begin
        // The quotient never exceeds the texture height in fixed point.
        texture_step_r <= div_quo[STEP_W-1:0];
      end
      if (state_r == S_FIN) begin
        texture_position_r <= mul_p[TPOS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (setup_fire) begin
      dist_r <= in_dist;
      if (in_side) begin
        pos_r    <= in_px;
        ray_r    <= in_rx;
        mirror_r <= in_ry[RAY_W-1];
      end else begin
        pos_r    <= in_py;
        ray_r    <= in_ry;
        mirror_r <= !in_rx[RAY_W-1] && (in_rx != '0);
      end
    end
    if ((state_r == S_DIV_H) && div_stat.done) begin
      height_r <= (div_quo > DIV_W'(HEIGHT_MAX)) ? HEIGHT_MAX : div_quo[HGT_W-1:0];
    end
    if (state_r == S_WALL) begin
      offset_r      <= span_ofs;
      pend_active_r <= span_start < span_stop;
    end
    if (step_fire && span_active_r) begin
      out_sx_r   <= held_column_r;
      out_sy_r   <= current_row_r;
      out_tx_r   <= held_texel_x_r;
      out_ty_r   <= texture_position_r[FRACTION_BITS +: TEXY_W];
      out_face_r <= held_face_r;
      out_last_r <= last_w;
    end
  end

  wcts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  wcts_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_W'({out_face_r, out_ty_r, out_tx_r, out_sy_r, out_sx_r});

  // The divider only runs while the sequencer waits on a division.
  a_div_only_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV_H) || (state_r == S_DIV_STEP))
    else $error("divider busy outside a division state");

  // An active span always has a row left to emit.
  a_span_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    span_active_r |-> (current_row_r < span_end_r))
    else $error("active span with current row at or past its end");

  // Emitting the final pixel closes the span.
  a_last_closes_span: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && span_active_r && last_w) |=> !span_active_r)
    else $error("span still active after its last pixel");

endmodule

/* dv/wcts_span_checker.sv */
`timescale 1ns / 100ps
// Checker for the wall column texture stepper: watches both streams, predicts each pixel
// from the column setups and compares the pixel items field by field. Depends on wcts_pkg.
module wcts_span_checker
  import wcts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // Fields from bit 0 up: column, wall_distance, hit_side, player_x,
  // player_y, ray_x, ray_y, wall_face, then zero padding.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Fields: operation.
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0 up: screen_x, screen_y, texel_x, texel_y, texture_face.
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  output int                    errors,
  output int                    pending,
  output int                    work_items,
  output int                    columns,
  output int                    pixels_checked,
  output int                    stray_steps
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [COL_W-1:0]  screen_x;
    logic [ROW_W-1:0]  screen_y;
    logic [TEXX_W-1:0] texel_x;
    logic [TEXY_W-1:0] texel_y;
    logic [FACE_W-1:0] face;
    logic              last;
  } pixel_t;

  // Predicted span state, mirroring what the block holds between items.
  logic              span_on;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_end;
  logic [COL_W-1:0]  col_hold;
  logic [TEXX_W-1:0] texx_hold;
  logic [FACE_W-1:0] face_hold;
  logic [STEP_W-1:0] step_hold;
  logic [TPOS_W-1:0] tex_pos;

  pixel_t pixels_due[$];
  pixel_t want;
  pixel_t got;

  // Works out the span, the texture column and the texture walk of one column.
  task automatic load_column(input logic [IN_DATA_W-1:0] d);
    logic [DIST_W-1:0]       wall_dist;
    logic                    side;
    logic [POS_W-1:0]        pos;
    logic signed [RAY_W-1:0] rx;
    logic signed [RAY_W-1:0] ry;
    u64_t                    hgt;
    u64_t                    top_row;
    u64_t                    end_row;
    u64_t                    hit;
    u64_t                    frac;
    u64_t                    tex;
    u64_t                    step_q;
    longint                  along;
    wall_dist = d[IN_DIST_LSB +: DIST_W];
    side = d[IN_SIDE_LSB];
    rx   = d[IN_RX_LSB +: RAY_W];
    ry   = d[IN_RY_LSB +: RAY_W];
    pos  = side ? d[IN_PX_LSB +: POS_W] : d[IN_PY_LSB +: POS_W];

    // A zero distance means the wall is in our face: height saturates.
    if (wall_dist == 0) begin
      hgt = HEIGHT_MAX;
    end else begin
      hgt = (u64_t'(SCREEN_HEIGHT) << FRACTION_BITS) / wall_dist;
      if (hgt > HEIGHT_MAX) hgt = HEIGHT_MAX;
    end

    if (hgt / 2 > SCREEN_HEIGHT / 2) top_row = 0;
    else top_row = SCREEN_HEIGHT / 2 - hgt / 2;
    end_row = hgt / 2 + SCREEN_HEIGHT / 2;
    if (end_row >= SCREEN_HEIGHT) end_row = SCREEN_HEIGHT - 1;

    // The hit point along the wall keeps twice the fraction bits; its fraction
    // wraps like a floor toward minus infinity.
    along = longint'(wall_dist) * longint'(side ? rx : ry);
    hit   = (u64_t'(pos) << FRACTION_BITS) + u64_t'(along);
    frac  = hit & ((u64_t'(1) << FRAC2_W) - 1);
    tex   = (frac * TEXTURE_WIDTH) >> FRAC2_W;
    if ((!side && rx > 0) || (side && ry < 0)) tex = TEXTURE_WIDTH - 1 - tex;

    if (hgt == 0) begin
      step_q = 0;
    end else begin
      step_q = (u64_t'(TEXTURE_HEIGHT) << FRACTION_BITS) / hgt;
      if (step_q > 64'hFF_FFFF) step_q = 64'hFF_FFFF;
    end

    step_hold = STEP_W'(step_q);
    tex_pos   = TPOS_W'((top_row + hgt / 2 - SCREEN_HEIGHT / 2) * step_q);
    col_hold  = d[IN_COL_LSB +: COL_W];
    face_hold = d[IN_FACE_LSB +: FACE_W];
    texx_hold = TEXX_W'(tex);
    row       = ROW_W'(top_row);
    row_end   = ROW_W'(end_row);
    span_on   = top_row < end_row;
  endtask

  // Emits the pixel for the current row and walks down the texture.
  function automatic pixel_t next_pixel();
    pixel_t p;
    p.screen_x = col_hold;
    p.screen_y = row;
    p.texel_x  = texx_hold;
    p.texel_y  = TEXY_W'((tex_pos >> FRACTION_BITS) % TEXTURE_HEIGHT);
    p.face     = face_hold;
    p.last     = (row + 1) >= row_end;
    tex_pos    = tex_pos + step_hold;
    row        = ROW_W'(row + 1);
    if (p.last) span_on = 1'b0;
    return p;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      span_on   = 1'b0;
      row       = '0;
      row_end   = '0;
      col_hold  = '0;
      texx_hold = '0;
      face_hold = '0;
      step_hold = '0;
      tex_pos   = '0;
      pixels_due.delete();
      pending   = 0;
    end else begin
      // Outputs first: a pixel leaving now was predicted at an earlier edge.
      if (out_tvalid && out_tready) begin
        got.screen_x = out_tdata[OUT_SX_LSB +: COL_W];
        got.screen_y = out_tdata[OUT_SY_LSB +: ROW_W];
        got.texel_x  = out_tdata[OUT_TX_LSB +: TEXX_W];
        got.texel_y  = out_tdata[OUT_TY_LSB +: TEXY_W];
        got.face     = out_tdata[OUT_FACE_LSB +: FACE_W];
        got.last     = out_tlast;
        if (pixels_due.size() == 0) begin
          $error("pixel at x %0d y %0d arrived with none expected", got.screen_x,
                 got.screen_y);
          errors++;
        end else begin
          want = pixels_due.pop_front();
          check_field("screen_x", want.screen_x, got.screen_x);
          check_field("screen_y", want.screen_y, got.screen_y);
          check_field("texel_x", want.texel_x, got.texel_x);
          check_field("texel_y", want.texel_y, got.texel_y);
          check_field("texture_face", want.face, got.face);
          check_field("last_pixel", want.last, got.last);
        end
        pixels_checked++;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_SETUP) begin
          load_column(in_tdata);
          columns++;
          work_items++;
        end else if (span_on) begin
          pixels_due.push_back(next_pixel());
          work_items++;
        end else begin
          stray_steps++;
        end
      end
      pending = pixels_due.size();
    end
  end

endmodule

/* dv/tb_wall_column_texture_stepper.sv */
`timescale 1ns / 100ps
// Testbench top for the wall column texture stepper: clock, reset, stimulus and verdict.
// Depends on wcts_pkg, the block itself and the wcts_span_checker module.
module tb_wall_column_texture_stepper;
  import wcts_pkg::*;

  // Generous bound on the whole run; a correct run takes a small fraction of it.
  localparam int CYCLE_LIMIT   = 400000;
  // The final wait covers the time a column setup keeps the block busy,
  // with some margin.
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS   = 300;

  localparam logic signed [RAY_W-1:0] RAY_MAX = {1'b0, {(RAY_W-1){1'b1}}};
  localparam logic signed [RAY_W-1:0] RAY_MIN = {1'b1, {(RAY_W-1){1'b0}}};

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = OP_SETUP;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int errors;
  int pending;
  int work_items;
  int columns;
  int pixels_checked;
  int stray_steps;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  wall_column_texture_stepper DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  wcts_span_checker span_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .errors        (errors),
    .pending       (pending),
    .work_items    (work_items),
    .columns       (columns),
    .pixels_checked(pixels_checked),
    .stray_steps   (stray_steps)
  );

  // The receiver stalls at random, at the rate the current phase sets.
  always @(negedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake or a lost pixel ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles with %0d pixels outstanding", CYCLE_LIMIT, pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_column(
    input logic [COL_W-1:0]       col,
    input logic [DIST_W-1:0]      dist_in,
    input logic                   side,
    input logic [POS_W-1:0]       px,
    input logic [POS_W-1:0]       py,
    input logic signed [RAY_W-1:0] rx,
    input logic signed [RAY_W-1:0] ry,
    input logic [FACE_W-1:0]      face
  );
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[IN_COL_LSB +: COL_W]   = col;
    d[IN_DIST_LSB +: DIST_W] = dist_in;
    d[IN_SIDE_LSB]           = side;
    d[IN_PX_LSB +: POS_W]    = px;
    d[IN_PY_LSB +: POS_W]    = py;
    d[IN_RX_LSB +: RAY_W]    = rx;
    d[IN_RY_LSB +: RAY_W]    = ry;
    d[IN_FACE_LSB +: FACE_W] = face;
    return d;
  endfunction

  // Ray components: mostly random, with zero, plus and minus one and the
  // two extremes mixed in so the mirroring edges get hit often.
  function automatic logic signed [RAY_W-1:0] pick_ray();
    case ($urandom_range(9))
      0: return '0;
      1: return RAY_W'(1);
      2: return '1;
      3: return RAY_MAX;
      4: return RAY_MIN;
      default: return RAY_W'($urandom);
    endcase
  endfunction

  // Presents one item and returns at the falling edge after it was taken.
  // Called at a falling edge; valid is only lowered while the sender idles,
  // so it never sees two assignments in one time step.
  task automatic send(input op_t op, input logic [IN_DATA_W-1:0] d);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Pixel steps carry random junk in the fields the block should ignore.
  task automatic send_steps(input int n);
    repeat (n) begin
      send(OP_STEP, pack_column(COL_W'($urandom), DIST_W'($urandom), 1'($urandom),
                                POS_W'($urandom), POS_W'($urandom), RAY_W'($urandom),
                                RAY_W'($urandom), FACE_W'($urandom)));
    end
  endtask

  // One column: a setup followed by a run of pixel steps. Most runs are
  // short and finish the span or stop in the middle of it; a few walk a
  // tall span to its end. Now and then stray steps come first.
  task automatic random_column();
    logic [DIST_W-1:0] wall_dist;
    int                mode;
    int                n;
    if ($urandom_range(99) < 6) send_steps($urandom_range(1, 3));
    mode = $urandom_range(99);
    if (mode < 55) begin
      wall_dist = DIST_W'($urandom_range(524288, 24'hFF_FFFF));
    end else if (mode < 70) begin
      wall_dist = DIST_W'($urandom);
    end else if (mode < 85) begin
      wall_dist = DIST_W'($urandom_range(65536, 524288));
    end else if (mode < 95) begin
      wall_dist = DIST_W'($urandom_range(0, 65536));
    end else begin
      case ($urandom_range(4))
        0: wall_dist = '0;
        1: wall_dist = 24'd1;
        2: wall_dist = 24'hFF_FFFF;
        3: wall_dist = 24'd15728640;
        default: wall_dist = 24'd10485760;
      endcase
    end
    send(OP_SETUP, pack_column(COL_W'($urandom), wall_dist, 1'($urandom), POS_W'($urandom),
                               POS_W'($urandom), pick_ray(), pick_ray(),
                               FACE_W'($urandom)));
    if ($urandom_range(99) < 4) n = $urandom_range(100, 490);
    else n = $urandom_range(0, 18);
    send_steps(n);
  endtask

  initial begin
    int goal;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening. A step straight after reset finds no span.
    send_steps(1);
    // Zero distance saturates the height; side 0 with ray_x positive mirrors
    // the texture column.
    send(OP_SETUP, pack_column(10'd1023, '0, 1'b0, '0, 24'hFF_FFFF, RAY_MAX, RAY_MAX, 2'd0));
    send_steps(3);
    // Largest distance gives a unit height and an empty span; it also drops
    // the span left over from the previous column.
    send(OP_SETUP, pack_column(10'd0, 24'hFF_FFFF, 1'b0, '0, '0, RAY_MIN, RAY_MIN, 2'd1));
    send_steps(1);
    // Height two: a two-row span; side 1 with ray_y negative mirrors. The
    // third step falls past the end of the span.
    send(OP_SETUP, pack_column(10'd512, 24'd15728640, 1'b1, 24'hFF_FFFF, '0, RAY_MIN, '1,
                               2'd3));
    send_steps(3);
    // Odd height of three, negative ray_x on side 0 (no mirroring).
    send(OP_SETUP, pack_column(10'd1, 24'd10485760, 1'b0, 24'h00_8000, 24'h01_8000, '1, '0,
                               2'd2));
    send_steps(2);
    // Height exactly the screen: the span is clamped at the last row.
    send(OP_SETUP, pack_column(10'd700, 24'd65536, 1'b1, 24'h12_3456, 24'hAB_CDEF, RAY_MAX,
                               RAY_MAX, 2'd2));
    send_steps(2);
    // Distance one saturates as well; the random part then cuts this span.
    send(OP_SETUP, pack_column(10'd333, 24'd1, 1'b1, 24'h55_AA55, 24'hAA_55AA, '0, '0, 2'd1));
    send_steps(1);

    // Random part in four idling phases: none, sender idle, receiver
    // stalling, then both at a lighter rate.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      goal = work_items + PHASE_ITEMS;
      while (work_items < goal) random_column();
    end
    in_tvalid <= 1'b0;

    // Drain: every predicted pixel must come out, and nothing after it.
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d column setups and %0d pixels, with %0d steps outside any span,",
             columns, pixels_checked, stray_steps);
    $display("in %0d cycles across idle-free, sender-idle, receiver-stall and mixed phases.",
             cycles);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
